/* src/assert_macros.svh */
// assertion helpers used by greedy_block_merge_relabel
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, held off while reset is high
`define GMR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define GMR_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GMR_ASSERT(name, clk, rst, prop, msg)
`define GMR_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

/* src/gmr_pkg.sv */
package gmr_pkg;

   // default sizes
   localparam int MAX_BLOCKS_DEF   = 256;
   localparam int MAX_VERTICES_DEF = 4096;
   localparam int COST_BITS_DEF    = 32;

   // label space is fixed by the 8-bit label field
   localparam int LABEL_BITS  = 8;
   localparam int LABEL_SPACE = 256;

   // register widths and reset values
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int BCOUNT_BITS    = 9;
   localparam int MERGE_BITS     = 8;
   localparam int VCOUNT_BITS    = 13;
   localparam logic [BCOUNT_BITS-1:0] BCOUNT_RESET = 9'd256;
   localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 13'd4096;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MERGES_WANTED = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_COUNT  = 2'd2;

   // operation codes
   localparam logic [1:0] FUNC_LOAD_BLOCK  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_VERTEX = 2'd1;
   localparam logic [1:0] FUNC_RUN         = 2'd2;
   localparam logic [1:0] FUNC_READ        = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_ACCEPTED  = 2'd0;
   localparam logic [1:0] STATUS_DONE      = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic [11:0]        index;
      logic signed [31:0] merge_cost;
      logic [7:0]         merge_target;
      logic [7:0]         vertex_label;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] label_out;
      logic [8:0] blocks_left;
   } rsp_type;

endpackage

/* src/greedy_block_merge_relabel.sv */
// Greedy block merge with label compaction.
// req_* carries one beat per command (valid/ready): load a block's cost and
// target, load a vertex label, run the merges, or read a vertex label back.
// rsp_* returns exactly one beat per command with status, label and the
// block count left after the last run. csr_* writes block_count,
// merges_wanted and vertex_count; write them only while the block is idle,
// which the block does not check. Loads answer in the next cycle, a read
// after S_RD; a new command is taken in the cycle the last response is.
// A run is done by one sequencer over memories with one registered read
// port each: identity fill, rank sort (one signed cost comparator), per
// merge a redirect over n blocks and a relabel over v vertices, then a
// clear of 256 used flags, a mark, a 256-label rank and a relabel over v.
// req_ready is low during a run or read. If the receiver stalls rsp, the
// response holds and no new command is taken until it is taken.
// Synchronous reset clears the control state and sets the registers to
// 256 blocks, 0 merges and 4096 vertices; memory contents are not cleared.
module greedy_block_merge_relabel #(
   parameter int MAX_BLOCKS   = gmr_pkg::MAX_BLOCKS_DEF,
   parameter int MAX_VERTICES = gmr_pkg::MAX_VERTICES_DEF,
   parameter int COST_BITS    = gmr_pkg::COST_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  gmr_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output gmr_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_enable,
   input  logic [gmr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gmr_pkg::CSR_DATA_BITS-1:0]   csr_data
);

`include "assert_macros.svh"

   localparam int BW  = $clog2(MAX_BLOCKS);
   localparam int NBW = $clog2(MAX_BLOCKS + 1);
   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int NVW = $clog2(MAX_VERTICES + 1);
   localparam int LW  = gmr_pkg::LABEL_BITS;
   localparam int T1  = (NVW > NBW) ? NVW : NBW;
   localparam int IW  = (T1 > LW + 1) ? T1 : LW + 1;
   localparam int RW  = (NBW > LW + 1) ? NBW : LW + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_RD, S_INIT, S_SO_RDI, S_SO_LDI, S_SO_RJ, S_SO_CJ, S_SO_WR,
      S_MG_CHK, S_MG_FROM, S_MG_TGT, S_MG_TO, S_MG_RR, S_MG_RW, S_MG_LR,
      S_MG_LW, S_CL, S_CU_R, S_CU_W, S_RK_R, S_RK_W, S_RL_R, S_RL_M,
      S_RL_W, S_DONE
   } state_type;

   state_type                           state_ff, state_in;
   logic [gmr_pkg::BCOUNT_BITS-1:0]     bcount_ff, bcount_in;
   logic [gmr_pkg::MERGE_BITS-1:0]      mwant_ff, mwant_in;
   logic [gmr_pkg::VCOUNT_BITS-1:0]     vcount_ff, vcount_in;
   logic [IW-1:0]                       i_ff, i_in;
   logic [NBW-1:0]                      j_ff, j_in;
   logic [RW-1:0]                       rank_ff, rank_in;
   logic [NBW-1:0]                      pos_ff, pos_in;
   logic [gmr_pkg::MERGE_BITS-1:0]      merged_ff, merged_in;
   logic [NBW-1:0]                      n_ff, n_in;
   logic [NVW-1:0]                      nv_ff, nv_in;
   logic [BW-1:0]                       from_ff, from_in;
   logic [BW-1:0]                       to_ff, to_in;
   logic [COST_BITS-1:0]                cost_i_ff, cost_i_in;
   logic [1:0]                          status_ff, status_in;
   logic [8:0]                          cur_blocks_ff, cur_blocks_in;
   logic                                rd_ok_ff, rd_ok_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   gmr_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   // memory ports
   logic                 cost_we, target_we, label_we, sorted_we, redir_we;
   logic                 used_we, map_we;
   logic [BW-1:0]        cost_wa, cost_ra, target_wa, target_ra;
   logic [BW-1:0]        sorted_wa, sorted_ra, redir_wa, redir_ra;
   logic [VW-1:0]        label_wa, label_ra;
   logic [LW-1:0]        used_wa, used_ra, map_wa, map_ra;
   logic [COST_BITS-1:0] cost_wd, cost_rd;
   logic [7:0]           target_rd;
   logic [LW-1:0]        label_wd, label_rd, map_wd, map_rd;
   logic [BW-1:0]        sorted_wd, sorted_rd, redir_wd, redir_rd;
   logic                 used_wd, used_rd;
   logic                 cost_less;
   logic                 accept;

   gmr_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_BLOCKS)) u_cost (
      .clock(clock), .wr_en(cost_we), .wr_addr(cost_wa), .wr_data(cost_wd),
      .rd_addr(cost_ra), .rd_data(cost_rd));
   gmr_ram #(.WIDTH(8), .DEPTH(MAX_BLOCKS)) u_target (
      .clock(clock), .wr_en(target_we), .wr_addr(target_wa),
      .wr_data(req_data.merge_target), .rd_addr(target_ra), .rd_data(target_rd));
   gmr_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_label (
      .clock(clock), .wr_en(label_we), .wr_addr(label_wa), .wr_data(label_wd),
      .rd_addr(label_ra), .rd_data(label_rd));
   gmr_ram #(.WIDTH(BW), .DEPTH(MAX_BLOCKS)) u_sorted (
      .clock(clock), .wr_en(sorted_we), .wr_addr(sorted_wa), .wr_data(sorted_wd),
      .rd_addr(sorted_ra), .rd_data(sorted_rd));
   gmr_ram #(.WIDTH(BW), .DEPTH(MAX_BLOCKS)) u_redir (
      .clock(clock), .wr_en(redir_we), .wr_addr(redir_wa), .wr_data(redir_wd),
      .rd_addr(redir_ra), .rd_data(redir_rd));
   gmr_ram #(.WIDTH(1), .DEPTH(gmr_pkg::LABEL_SPACE)) u_used (
      .clock(clock), .wr_en(used_we), .wr_addr(used_wa), .wr_data(used_wd),
      .rd_addr(used_ra), .rd_data(used_rd));
   gmr_ram #(.WIDTH(LW), .DEPTH(gmr_pkg::LABEL_SPACE)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
      .rd_addr(map_ra), .rd_data(map_rd));

   // rank sort comparator: stable ascending order, lower index wins a tie
   assign cost_less = ($signed(cost_rd) < $signed(cost_i_ff)) ||
                      ((cost_rd == cost_i_ff) && (32'(j_ff) < 32'(i_ff)));

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // cost kept sign-extended or truncated to the stored width
   assign cost_wd = COST_BITS'(req_data.merge_cost);

   // configuration writes
   always_comb begin
      bcount_in = bcount_ff;
      mwant_in  = mwant_ff;
      vcount_in = vcount_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            gmr_pkg::CSR_BLOCK_COUNT:   bcount_in = csr_data[gmr_pkg::BCOUNT_BITS-1:0];
            gmr_pkg::CSR_MERGES_WANTED: mwant_in  = csr_data[gmr_pkg::MERGE_BITS-1:0];
            gmr_pkg::CSR_VERTEX_COUNT:  vcount_in = csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      rank_in       = rank_ff;
      pos_in        = pos_ff;
      merged_in     = merged_ff;
      n_in          = n_ff;
      nv_in         = nv_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      cost_i_in     = cost_i_ff;
      status_in     = status_ff;
      cur_blocks_in = cur_blocks_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      cost_we   = 1'b0;
      target_we = 1'b0;
      label_we  = 1'b0;
      sorted_we = 1'b0;
      redir_we  = 1'b0;
      used_we   = 1'b0;
      map_we    = 1'b0;
      cost_wa   = BW'(req_data.index);
      target_wa = BW'(req_data.index);
      cost_ra   = i_ff[BW-1:0];
      target_ra = sorted_rd;
      label_wa  = i_ff[VW-1:0];
      label_ra  = i_ff[VW-1:0];
      label_wd  = map_rd;
      sorted_wa = rank_ff[BW-1:0];
      sorted_wd = i_ff[BW-1:0];
      sorted_ra = pos_ff[BW-1:0];
      redir_wa  = i_ff[BW-1:0];
      redir_wd  = to_ff;
      redir_ra  = i_ff[BW-1:0];
      used_wa   = i_ff[LW-1:0];
      used_wd   = 1'b0;
      used_ra   = i_ff[LW-1:0];
      map_wa    = i_ff[LW-1:0];
      map_wd    = rank_ff[LW-1:0];
      map_ra    = label_rd;

      unique case (state_ff)
         S_IDLE: begin
            label_wa = VW'(req_data.index);
            label_wd = req_data.vertex_label;
            label_ra = VW'(req_data.index);
            if (accept) begin
               rsp_data_in.status      = gmr_pkg::STATUS_ACCEPTED;
               rsp_data_in.label_out   = '0;
               rsp_data_in.blocks_left = cur_blocks_ff;
               unique case (req_data.func)
                  gmr_pkg::FUNC_LOAD_BLOCK: begin
                     rsp_valid_in = 1'b1;
                     if (32'(req_data.index) < MAX_BLOCKS) begin
                        cost_we   = 1'b1;
                        target_we = 1'b1;
                     end
                  end
                  gmr_pkg::FUNC_LOAD_VERTEX: begin
                     rsp_valid_in = 1'b1;
                     label_we     = (32'(req_data.index) < MAX_VERTICES);
                  end
                  gmr_pkg::FUNC_RUN: begin
                     n_in      = (32'(bcount_ff) > MAX_BLOCKS) ? NBW'(MAX_BLOCKS)
                                                               : NBW'(bcount_ff);
                     nv_in     = (32'(vcount_ff) > MAX_VERTICES) ? NVW'(MAX_VERTICES)
                                                                 : NVW'(vcount_ff);
                     i_in      = '0;
                     pos_in    = '0;
                     merged_in = '0;
                     state_in  = S_INIT;
                  end
                  default: begin
                     rd_ok_in = (32'(req_data.index) < MAX_VERTICES);
                     state_in = S_RD;
                  end
               endcase
            end
         end
         S_RD: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.status    = gmr_pkg::STATUS_ACCEPTED;
            rsp_data_in.label_out = rd_ok_ff ? label_rd : '0;
            rsp_data_in.blocks_left = cur_blocks_ff;
            state_in = S_IDLE;
         end
         // block map starts as identity
         S_INIT: begin
            if (32'(i_ff) == 32'(n_ff)) begin
               i_in     = '0;
               state_in = S_SO_RDI;
            end else begin
               redir_we = 1'b1;
               redir_wd = i_ff[BW-1:0];
               i_in     = i_ff + 1'b1;
            end
         end
         // rank sort: count the blocks that go before block i
         S_SO_RDI: begin
            j_in    = '0;
            rank_in = '0;
            state_in = (32'(i_ff) == 32'(n_ff)) ? S_MG_CHK : S_SO_LDI;
         end
         S_SO_LDI: begin
            cost_i_in = cost_rd;
            state_in  = S_SO_RJ;
         end
         S_SO_RJ: begin
            cost_ra  = j_ff[BW-1:0];
            state_in = (j_ff == n_ff) ? S_SO_WR : S_SO_CJ;
         end
         S_SO_CJ: begin
            if (cost_less) begin
               rank_in = rank_ff + 1'b1;
            end
            j_in     = j_ff + 1'b1;
            state_in = S_SO_RJ;
         end
         S_SO_WR: begin
            sorted_we = 1'b1;
            i_in      = i_ff + 1'b1;
            state_in  = S_SO_RDI;
         end
         // next candidate or stop
         S_MG_CHK: begin
            i_in = '0;
            if (merged_ff == mwant_ff) begin
               status_in = gmr_pkg::STATUS_DONE;
               state_in  = S_CL;
            end else if (pos_ff == n_ff) begin
               status_in = gmr_pkg::STATUS_EXHAUSTED;
               state_in  = S_CL;
            end else begin
               state_in = S_MG_FROM;
            end
         end
         S_MG_FROM: begin
            from_in  = sorted_rd;
            pos_in   = pos_ff + 1'b1;
            state_in = S_MG_TGT;
         end
         S_MG_TGT: begin
            redir_ra = BW'(target_rd);
            state_in = (32'(target_rd) >= 32'(n_ff)) ? S_MG_CHK : S_MG_TO;
         end
         S_MG_TO: begin
            to_in    = redir_rd;
            i_in     = '0;
            state_in = (redir_rd == from_ff) ? S_MG_CHK : S_MG_RR;
         end
         // redirect every block that maps to the merged one
         S_MG_RR: begin
            if (32'(i_ff) == 32'(n_ff)) begin
               i_in     = '0;
               state_in = S_MG_LR;
            end else begin
               state_in = S_MG_RW;
            end
         end
         S_MG_RW: begin
            redir_we = (redir_rd == from_ff);
            i_in     = i_ff + 1'b1;
            state_in = S_MG_RR;
         end
         // relabel its vertices
         S_MG_LR: begin
            if (32'(i_ff) == 32'(nv_ff)) begin
               merged_in = merged_ff + 1'b1;
               state_in  = S_MG_CHK;
            end else begin
               state_in = S_MG_LW;
            end
         end
         S_MG_LW: begin
            label_we = (32'(label_rd) == 32'(from_ff));
            label_wd = LW'(to_ff);
            i_in     = i_ff + 1'b1;
            state_in = S_MG_LR;
         end
         // clear the used flags
         S_CL: begin
            if (32'(i_ff) == gmr_pkg::LABEL_SPACE) begin
               i_in     = '0;
               state_in = S_CU_R;
            end else begin
               used_we = 1'b1;
               i_in    = i_ff + 1'b1;
            end
         end
         // mark labels in use
         S_CU_R: begin
            if (32'(i_ff) == 32'(nv_ff)) begin
               i_in     = '0;
               rank_in  = '0;
               state_in = S_RK_R;
            end else begin
               state_in = S_CU_W;
            end
         end
         S_CU_W: begin
            used_we  = 1'b1;
            used_wa  = label_rd;
            used_wd  = 1'b1;
            i_in     = i_ff + 1'b1;
            state_in = S_CU_R;
         end
         // ascending rank of used labels
         S_RK_R: begin
            if (32'(i_ff) == gmr_pkg::LABEL_SPACE) begin
               i_in     = '0;
               state_in = S_RL_R;
            end else begin
               state_in = S_RK_W;
            end
         end
         S_RK_W: begin
            map_we = 1'b1;
            map_wd = used_rd ? rank_ff[LW-1:0] : '0;
            if (used_rd) begin
               rank_in = rank_ff + 1'b1;
            end
            i_in     = i_ff + 1'b1;
            state_in = S_RK_R;
         end
         // rewrite vertex labels through the map
         S_RL_R: begin
            state_in = (32'(i_ff) == 32'(nv_ff)) ? S_DONE : S_RL_M;
         end
         S_RL_M: begin
            state_in = S_RL_W;
         end
         S_RL_W: begin
            label_we = 1'b1;
            i_in     = i_ff + 1'b1;
            state_in = S_RL_R;
         end
         S_DONE: begin
            cur_blocks_in           = 9'(32'(n_ff) - 32'(merged_ff));
            rsp_valid_in            = 1'b1;
            rsp_data_in.status      = status_ff;
            rsp_data_in.label_out   = '0;
            rsp_data_in.blocks_left = 9'(32'(n_ff) - 32'(merged_ff));
            state_in                = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bcount_ff     <= gmr_pkg::BCOUNT_RESET;
         mwant_ff      <= '0;
         vcount_ff     <= gmr_pkg::VCOUNT_RESET;
         cur_blocks_ff <= 9'd256;
         rsp_valid_ff  <= 1'b0;
         i_ff          <= '0;
         merged_ff     <= '0;
         pos_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         bcount_ff     <= bcount_in;
         mwant_ff      <= mwant_in;
         vcount_ff     <= vcount_in;
         cur_blocks_ff <= cur_blocks_in;
         rsp_valid_ff  <= rsp_valid_in;
         i_ff          <= i_in;
         merged_ff     <= merged_in;
         pos_ff        <= pos_in;
      end
      j_ff        <= j_in;
      rank_ff     <= rank_in;
      n_ff        <= n_in;
      nv_ff       <= nv_in;
      from_ff     <= from_in;
      to_ff       <= to_in;
      cost_i_ff   <= cost_i_in;
      status_ff   <= status_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `GMR_ASSERT(a_busy_no_rsp, clock, reset,
      (state_ff != S_IDLE) |-> !rsp_valid_ff, "response pending while busy")
   `GMR_ASSERT(a_merge_bound, clock, reset,
      ((state_ff != S_IDLE) && (state_ff != S_RD)) |-> (merged_ff <= mwant_ff),
      "more merges than requested")
   `GMR_ASSERT(a_sort_rank, clock, reset,
      (state_ff == S_SO_WR) |-> (32'(rank_ff) < 32'(n_ff)), "sort rank out of range")
   `GMR_ASSERT_ALWAYS(a_reset_idle, clock,
      $past(reset) |-> ((state_ff == S_IDLE) && !rsp_valid_ff), "not idle after reset")

endmodule

/* src/gmr_ram.sv */
module gmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
